>>> rtl/tuning_word_generator_unit_assert.svh
// assertion macros used by the tuning word generator rtl
`ifndef TUNING_WORD_GENERATOR_UNIT_ASSERT_SVH
`define TUNING_WORD_GENERATOR_UNIT_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define TWG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// same-cycle implication checked at every clock edge out of reset
`define TWG_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/twg_pkg.sv
// types, constants and the filter bandwidth table of the tuning word generator
`default_nettype none

package twg_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_MODE           = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_SELECT  = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PASSBAND_SHIFT = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CW_OFFSET      = 4'd3;

  typedef enum logic [1:0] {
    MODE_AM  = 2'd0,
    MODE_USB = 2'd1,
    MODE_LSB = 2'd2,
    MODE_CW  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic        [15:0] filter_select;
    logic signed [13:0] passband_shift;
    logic        [12:0] cw_offset;
  } cfg_t;

  // payload leaving the offset stages
  typedef struct packed {
    logic [25:0] adj_mag;
    logic        adj_neg;
    logic [15:0] bsum_mag;
    logic        bsum_neg;
  } front_t;

  localparam int NUM_FILTERS = 33;
  localparam logic [12:0] WIDE_BW = 13'd8000;

  localparam logic [12:0] FILT_BW [NUM_FILTERS] = '{
    13'd6000, 13'd5700, 13'd5400, 13'd5100, 13'd4800, 13'd4500, 13'd4200,
    13'd3900, 13'd3600, 13'd3300, 13'd3000, 13'd2850, 13'd2700, 13'd2550,
    13'd2400, 13'd2250, 13'd2100, 13'd1950, 13'd1800, 13'd1650, 13'd1500,
    13'd1350, 13'd1200, 13'd1050, 13'd900,  13'd750,  13'd675,  13'd600,
    13'd525,  13'd450,  13'd375,  13'd330,  13'd300
  };

  localparam logic [13:0] CORR_BIAS2   = 14'd400;    // 200 Hz in half-Hz units
  localparam logic [16:0] BFO_BIAS2    = 17'd16000;  // 8000 Hz in half-Hz units
  localparam logic [26:0] FREQ_BIAS    = 27'd1250;
  localparam logic [15:0] COARSE_BASE  = 16'd18000;
  localparam logic [11:0] COARSE_DIV   = 12'd2500;
  localparam logic [8:0]  SCALE_MUL    = 9'd273;

  // reciprocals, exact over the operand ranges used
  localparam logic [24:0] RECIP_625      = 25'd27487791;  // 2^34 / 625, n < 2^24
  localparam logic [21:0] RECIP_25_BFO   = 22'd2684355;   // 2^26 / 25,  n < 2^21
  localparam logic [19:0] RECIP_25_FINE  = 20'd671089;    // 2^24 / 25,  n < 2^19

  // filter number, or widest table bandwidth not above a requested bandwidth
  function automatic logic [12:0] pick_bandwidth(input logic [15:0] sel);
    logic [12:0] bw;
    bw = FILT_BW[NUM_FILTERS-1];
    if (sel == 16'(NUM_FILTERS)) begin
      bw = WIDE_BW;
    end else if (sel < 16'(NUM_FILTERS)) begin
      bw = FILT_BW[sel[5:0]];
    end else if (sel >= {3'b000, WIDE_BW}) begin
      bw = WIDE_BW;
    end else begin
      for (int i = NUM_FILTERS - 1; i >= 0; i--) begin
        if (sel >= {3'b000, FILT_BW[i]}) begin
          bw = FILT_BW[i];
        end
      end
    end
    return bw;
  endfunction

endpackage

`default_nettype wire

>>> rtl/twg_cfg.sv
// configuration register file of the tuning word generator
`default_nettype none

module twg_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [twg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [twg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output twg_pkg::cfg_t                         cfg
);
  import twg_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode           <= MODE_AM;
      cfg_r.filter_select  <= 16'(NUM_FILTERS);
      cfg_r.passband_shift <= '0;
      cfg_r.cw_offset      <= 13'd1000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:           cfg_r.mode           <= mode_t'(cfg_data[1:0]);
        REG_FILTER_SELECT:  cfg_r.filter_select  <= cfg_data;
        REG_PASSBAND_SHIFT: cfg_r.passband_shift <= $signed(cfg_data[13:0]);
        REG_CW_OFFSET:      cfg_r.cw_offset      <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/twg_front.sv
// offset stages: filter correction, signed frequency adjust and bfo sum
`default_nettype none

module twg_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire twg_pkg::cfg_t   cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [24:0]     in_frequency_hz,
  output logic                 dn_valid,
  input  wire logic            dn_ready,
  output twg_pkg::front_t      dn_item
);
  import twg_pkg::*;

  logic        v1_r, v2_r;
  logic        en1, en2;

  // stage 1
  logic [12:0]        bw;
  logic [13:0]        corr2;
  logic signed [15:0] s1_sum_nxt;
  logic [13:0]        s1_cbfo2_nxt;
  logic [24:0]        s1_freq_r;
  logic signed [15:0] s1_sum_r;
  logic [13:0]        s1_cbfo2_r;
  mode_t              s1_mode_r;

  // stage 2
  logic signed [15:0] half_adj;
  logic signed [14:0] half;
  logic signed [15:0] tweak;
  logic signed [26:0] adj;
  logic signed [16:0] bsum;
  front_t             s2_nxt;
  front_t             s2_r;

  assign en2      = !v2_r || dn_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign dn_valid = v2_r;
  assign dn_item  = s2_r;

  always_comb begin
    bw           = pick_bandwidth(cfg.filter_select);
    corr2        = (cfg.mode == MODE_CW) ? 14'd0 : ({1'b0, bw} + CORR_BIAS2);
    s1_sum_nxt   = $signed({2'b00, corr2})
                 + $signed({cfg.passband_shift[13], cfg.passband_shift, 1'b0});
    s1_cbfo2_nxt = (cfg.mode == MODE_CW) ? {cfg.cw_offset, 1'b0} : 14'd0;
  end

  always_comb begin
    // halve toward zero
    half_adj = s1_sum_r + $signed({15'd0, s1_sum_r[15]});
    half     = $signed(half_adj[15:1]);
    unique case (s1_mode_r)
      MODE_AM:  tweak = '0;
      MODE_USB: tweak = {half[14], half};
      MODE_LSB: tweak = -{half[14], half};
      MODE_CW:  tweak = -{half[14], half};
    endcase
    adj  = $signed({2'b00, s1_freq_r}) - $signed(FREQ_BIAS)
         + $signed({{11{tweak[15]}}, tweak});
    bsum = $signed({s1_sum_r[15], s1_sum_r}) + $signed({3'b000, s1_cbfo2_r})
         + $signed(BFO_BIAS2);
    s2_nxt.adj_neg  = adj[26];
    s2_nxt.adj_mag  = adj[26] ? 26'(-adj) : adj[25:0];
    s2_nxt.bsum_neg = bsum[16];
    s2_nxt.bsum_mag = bsum[16] ? 16'(-bsum) : bsum[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_freq_r  <= in_frequency_hz;
      s1_sum_r   <= s1_sum_nxt;
      s1_cbfo2_r <= s1_cbfo2_nxt;
      s1_mode_r  <= cfg.mode;
    end
    if (en2) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/twg_div.sv
// scaling stages: divide by 2500, remainder and bfo scaling by reciprocals
`default_nettype none

module twg_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire twg_pkg::front_t up_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [15:0]          out_coarse_word,
  output logic [15:0]          out_fine_word,
  output logic [15:0]          out_bfo_word
);
  import twg_pkg::*;

  logic v3_r, v4_r, v5_r, v6_r;
  logic en3, en4, en5, en6;

  // stage 3: quotient and bfo product
  logic [48:0] q_prod;
  logic [14:0] s3_q_r;
  logic [25:0] s3_mag_r;
  logic        s3_neg_r;
  logic [23:0] s3_pb_r;
  logic        s3_bneg_r;

  // stage 4: remainder and bfo quotient
  logic [25:0] q_times;
  logic [25:0] r_full;
  logic [42:0] b_prod;
  logic [11:0] s4_r_r;
  logic [14:0] s4_q_r;
  logic        s4_neg_r;
  logic [16:0] s4_bq_r;
  logic        s4_bneg_r;

  // stage 5: fine product, coarse and bfo words
  logic [15:0] s5_coarse_nxt;
  logic [15:0] s5_bfo_nxt;
  logic [19:0] s5_pf_r;
  logic [15:0] s5_coarse_r;
  logic [15:0] s5_bfo_r;
  logic        s5_neg_r;

  // stage 6: fine quotient into the output register
  logic [38:0] f_prod;
  logic [14:0] fq;
  logic [15:0] fine_nxt;
  logic [15:0] coarse_r, fine_r, bfo_r;

  assign en6      = !v6_r || out_ready;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign up_ready = en3;

  assign out_valid       = v6_r;
  assign out_coarse_word = coarse_r;
  assign out_fine_word   = fine_r;
  assign out_bfo_word    = bfo_r;

  always_comb begin
    q_prod  = 49'(up_item.adj_mag[25:2]) * 49'(RECIP_625);
    q_times = 26'(s3_q_r) * 26'(COARSE_DIV);
    r_full  = s3_mag_r - q_times;
    b_prod  = 43'(s3_pb_r[23:3]) * 43'(RECIP_25_BFO);
    s5_coarse_nxt = s4_neg_r ? (COARSE_BASE - 16'(s4_q_r)) : (COARSE_BASE + 16'(s4_q_r));
    s5_bfo_nxt    = s4_bneg_r ? (16'd0 - s4_bq_r[15:0]) : s4_bq_r[15:0];
    f_prod   = 39'(s5_pf_r[19:1]) * 39'(RECIP_25_FINE);
    fq       = f_prod[38:24];
    fine_nxt = s5_neg_r ? (16'd0 - {1'b0, fq}) : {1'b0, fq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en3) v3_r <= up_valid;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_q_r    <= q_prod[48:34];
      s3_mag_r  <= up_item.adj_mag;
      s3_neg_r  <= up_item.adj_neg;
      s3_pb_r   <= 24'(up_item.bsum_mag) * 24'(SCALE_MUL);
      s3_bneg_r <= up_item.bsum_neg;
    end
    if (en4) begin
      s4_r_r    <= r_full[11:0];
      s4_q_r    <= s3_q_r;
      s4_neg_r  <= s3_neg_r;
      s4_bq_r   <= b_prod[42:26];
      s4_bneg_r <= s3_bneg_r;
    end
    if (en5) begin
      s5_pf_r     <= 20'(s4_r_r) * 20'(SCALE_MUL);
      s5_coarse_r <= s5_coarse_nxt;
      s5_bfo_r    <= s5_bfo_nxt;
      s5_neg_r    <= s4_neg_r;
    end
    if (en6) begin
      coarse_r <= s5_coarse_r;
      fine_r   <= fine_nxt;
      bfo_r    <= s5_bfo_r;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tuning_word_generator_unit.sv
// top level of the tuning word generator: config registers and six-stage pipeline
//
// Turns a wanted frequency in Hz into the receiver's coarse, fine and BFO tuning
// words for the mode, filter, passband shift and CW offset held in four config
// registers (index 0 mode, 1 filter_select, 2 passband_shift, 3 cw_offset; other
// indexes are ignored, cfg_ready is always high). One item is taken per clock
// while in_ready is high, and each item's result shows on the output ports
// after passing the six register stages: two offset stages, then two
// reciprocal-multiply stages for the divide by 2500 and the BFO scale, then two
// stages for the remainder scale and sign restore.
// A low out_ready stalls the stages behind the output register
// only as far as they are full, so empty stages keep taking new items.
// Config writes belong in idle periods with the pipeline drained.
`default_nettype none

`include "tuning_word_generator_unit_assert.svh"

module tuning_word_generator_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // config write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [twg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [twg_pkg::CFG_DATA_W-1:0]   cfg_data,
  // request items
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [24:0]                      in_frequency_hz,
  // result items
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [15:0]                           out_coarse_word,
  output logic [15:0]                           out_fine_word,
  output logic [15:0]                           out_bfo_word
);
  import twg_pkg::*;

  cfg_t   cfg;
  logic   mid_valid;
  logic   mid_ready;
  front_t mid_item;

  // register file, written by the user only while the pipeline is drained; the block does not enforce this
  twg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stages 1-2: bandwidth lookup, half-Hz correction, adjusted frequency and bfo sum
  twg_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_frequency_hz (in_frequency_hz),
    .dn_valid        (mid_valid),
    .dn_ready        (mid_ready),
    .dn_item         (mid_item)
  );

  // stages 3-6: constant divides by reciprocal multiply, sign restore
  twg_div u_div (
    .clk             (clk),
    .rst_n           (rst_n),
    .up_valid        (mid_valid),
    .up_ready        (mid_ready),
    .up_item         (mid_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_coarse_word (out_coarse_word),
    .out_fine_word   (out_fine_word),
    .out_bfo_word    (out_bfo_word)
  );

  // a free output slot opens the whole ready chain
  `TWG_ASSERT_IMPLY(a_ready_chain, (!out_valid || out_ready), in_ready, "ready chain broken")
  // quotient of a 25-bit frequency keeps the coarse word between 17995 and 31426
  `TWG_ASSERT_IMPLY(a_coarse_range, out_valid,
    (out_coarse_word >= 16'd17995 && out_coarse_word <= 16'd31426), "coarse word out of range")
  // scaled remainder magnitude never exceeds 2499 * 5.46
  `TWG_ASSERT_IMPLY(a_fine_range, out_valid,
    (out_fine_word <= 16'd13644 || out_fine_word >= 16'd51892), "fine word out of range")
  // unit always takes config writes
  `TWG_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "config port not ready")

endmodule

`default_nettype wire

>>> verif/tb_tuning_word_generator_unit.sv
// self-checking testbench for the tuning word generator: directed corners, then random traffic
`default_nettype none

module tb_tuning_word_generator_unit;
  import twg_pkg::*;

  // run shape
  localparam int RESET_CYCLES   = 10;
  localparam int IDLE_PCT       = 7;       // percent chance of an idle gap on each side
  localparam int PIPE_SETTLE    = 10;      // six-stage pipe plus some margin
  localparam int RANDOM_PHASES  = 10;
  localparam int CALM_PHASE     = 4;       // this phase runs with no gaps on either side
  localparam int CALM_ITEMS     = 300;
  localparam int PHASE_ITEMS    = 128;
  // time for ~1500 items even with every stall, plus drains; far above that
  localparam int CYCLE_LIMIT    = 200000;

  // tuning arithmetic, all in half-Hz where noted
  localparam longint FREQ_OFFSET_HZ = 1250;
  localparam longint COARSE_STEP_HZ = 2500;
  localparam longint COARSE_BIAS    = 18000;
  localparam longint CORR_BIAS_HALF = 400;    // 200 Hz
  localparam longint BFO_BIAS_HALF  = 16000;  // 8000 Hz
  localparam longint FINE_NUM       = 546;
  localparam longint FINE_DEN       = 100;
  localparam longint BFO_NUM        = 273;
  localparam longint BFO_DEN_HALF   = 200;

  localparam int     FILTER_COUNT   = 33;
  localparam int     WIDEST_BW      = 8000;
  localparam int     FILTER_BW [FILTER_COUNT] = '{
    6000, 5700, 5400, 5100, 4800, 4500, 4200, 3900, 3600, 3300, 3000,
    2850, 2700, 2550, 2400, 2250, 2100, 1950, 1800, 1650, 1500, 1350,
    1200, 1050, 900,  750,  675,  600,  525,  450,  375,  330,  300
  };
  localparam int     EDGE_FREQS [3] = '{0, 1250, 30000000};

  typedef struct packed {
    logic [15:0] coarse;
    logic [15:0] fine;
    logic [15:0] bfo;
  } words_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [24:0] in_frequency_hz = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_coarse_word;
  logic [15:0] out_fine_word;
  logic [15:0] out_bfo_word;

  // our copy of the register file, updated as each write is accepted
  cfg_t        tuning_cfg;

  logic [24:0] freq_backlog [$];     // items waiting for the driver
  words_t      expected_words [$];   // predictions for accepted items, oldest first
  int          items_queued = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  logic        no_gaps = 1'b0;

  tuning_word_generator_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_frequency_hz (in_frequency_hz),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_coarse_word (out_coarse_word),
    .out_fine_word   (out_fine_word),
    .out_bfo_word    (out_bfo_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // filter number, or the widest table entry not above a requested bandwidth
  function automatic int bandwidth_for(input logic [15:0] sel);
    if (sel == 16'(FILTER_COUNT)) begin
      return WIDEST_BW;
    end
    if (sel < 16'(FILTER_COUNT)) begin
      return FILTER_BW[sel[5:0]];
    end
    if (int'(sel) >= WIDEST_BW) begin
      return WIDEST_BW;
    end
    foreach (FILTER_BW[i]) begin
      if (int'(sel) >= FILTER_BW[i]) begin
        return FILTER_BW[i];
      end
    end
    // requests under the narrowest filter still get the narrowest one
    return FILTER_BW[FILTER_COUNT-1];
  endfunction

  // expected coarse, fine and bfo words for one frequency under the current registers
  function automatic words_t tuning_words(input logic [24:0] freq);
    longint corr_half;
    longint beat_half;
    longint shift_half;
    longint sgn;
    longint adj;
    longint rem;
    words_t w;
    shift_half = 2 * longint'(tuning_cfg.passband_shift);
    // cw drops the filter correction and moves the bfo by the beat offset instead
    if (tuning_cfg.mode == MODE_CW) begin
      corr_half = 0;
      beat_half = 2 * longint'(tuning_cfg.cw_offset);
    end else begin
      corr_half = longint'(bandwidth_for(tuning_cfg.filter_select)) + CORR_BIAS_HALF;
      beat_half = 0;
    end
    case (tuning_cfg.mode)
      MODE_USB: sgn = 1;
      MODE_AM:  sgn = 0;
      default:  sgn = -1;
    endcase
    // sv signed divide and modulo truncate toward zero, so negative adj behaves as wanted
    adj = longint'(freq) - FREQ_OFFSET_HZ + (sgn * (corr_half + shift_half)) / 2;
    rem = adj % COARSE_STEP_HZ;
    w.coarse = 16'(adj / COARSE_STEP_HZ + COARSE_BIAS);
    w.fine   = 16'((rem * FINE_NUM) / FINE_DEN);
    w.bfo    = 16'(((corr_half + shift_half + beat_half + BFO_BIAS_HALF) * BFO_NUM)
                   / BFO_DEN_HALF);
    return w;
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MODE:           tuning_cfg.mode = mode_t'(data[1:0]);
      REG_FILTER_SELECT:  tuning_cfg.filter_select = data;
      REG_PASSBAND_SHIFT: tuning_cfg.passband_shift = data[13:0];
      REG_CW_OFFSET:      tuning_cfg.cw_offset = data[12:0];
      default: ;
    endcase
  endfunction

  // register write that leaves cfg_valid high so writes can go back to back
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
  endtask

  // all four registers; fill supplies the unused upper data bits
  task automatic write_settings(input cfg_t s, input logic [15:0] fill);
    write_reg(REG_MODE, {fill[15:2], s.mode});
    write_reg(REG_FILTER_SELECT, s.filter_select);
    write_reg(REG_PASSBAND_SHIFT, {fill[15:14], s.passband_shift});
    write_reg(REG_CW_OFFSET, {fill[15:13], s.cw_offset});
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_freq(input logic [24:0] freq);
    freq_backlog.insert(freq_backlog.size(), freq);
    items_queued++;
  endtask

  // wait for every queued item to come back, then let the pipe go quiet
  task automatic drain();
    while (results_seen < items_queued) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // corner settings: max shifts both ways, narrowest and widest filters,
  // bandwidth requests below the table, at the top and just under it
  function automatic cfg_t corner_setting(input int k);
    cfg_t s;
    case (k)
      0:       s = '{MODE_USB, 16'd0,     14'sd8000,  13'd0};
      1:       s = '{MODE_LSB, 16'd32,    -14'sd8000, 13'd8000};
      // cw with no beat and the most negative shift drives the bfo sum below zero
      2:       s = '{MODE_CW,  16'hFFFF,  14'sh2000,  13'd0};
      3:       s = '{MODE_CW,  16'd34,    14'sd8191,  13'd8191};
      4:       s = '{MODE_USB, 16'd299,   -14'sd1,    13'd1};
      5:       s = '{MODE_LSB, 16'd8000,  14'sd0,     13'd1000};
      default: s = '{MODE_AM,  16'd7999,  14'sd8191,  13'd0};
    endcase
    return s;
  endfunction

  function automatic cfg_t random_setting();
    cfg_t s;
    int   v;
    s.mode = mode_t'($urandom_range(3));
    case ($urandom_range(3))
      0, 1:    s.filter_select = 16'($urandom_range(FILTER_COUNT));
      2:       s.filter_select = 16'($urandom_range(8100, 34));
      default: s.filter_select = 16'($urandom);
    endcase
    v = $urandom_range(16000);
    s.passband_shift = ($urandom_range(9) == 0) ? 14'($urandom) : 14'(v - 8000);
    s.cw_offset = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(8000));
    return s;
  endfunction

  function automatic logic [24:0] random_freq();
    int v;
    case ($urandom_range(9))
      0: v = int'(25'($urandom));
      // near zero the adjusted frequency can go negative
      1: v = $urandom_range(6000);
      // straddle the coarse step boundaries
      2: v = $urandom_range(12000) * 2500 + 1250 + $urandom_range(6) - 3;
      default: v = $urandom_range(30000000);
    endcase
    return 25'(v);
  endfunction

  // request driver: hold the item until taken, then maybe load the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_words.insert(expected_words.size(), tuning_words(in_frequency_hz));
      end
      if (!in_valid || in_ready) begin
        if (freq_backlog.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid        <= 1'b1;
          in_frequency_hz <= freq_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic void check_field(input string field, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s mismatch: expected %0d (0x%04h), got %0d (0x%04h)",
                 field, want, want, got, got);
      end
    end
  endfunction

  // result monitor: compare each taken result with the oldest prediction
  always @(posedge clk) begin
    words_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result with no item pending: coarse %0d fine %0d bfo %0d",
                   out_coarse_word, out_fine_word, out_bfo_word);
        end
      end else begin
        want = expected_words.pop_front();
        check_field("coarse_word", want.coarse, out_coarse_word);
        check_field("fine_word", want.fine, out_fine_word);
        check_field("bfo_word", want.bfo, out_bfo_word);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_tuning_word_generator_unit: errors");
    $finish;
  end

  initial begin
    int n;
    tuning_cfg = '{MODE_AM, 16'd33, 14'sd0, 13'd1000};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: bottom, either side of the offset, every bit set
    queue_freq(25'd0);
    queue_freq(25'd1249);
    queue_freq(25'd1251);
    queue_freq(25'h1FFFFFF);
    drain();

    // every mode against extreme registers, with the edge frequencies
    for (int k = 0; k < 7; k++) begin
      write_settings(corner_setting(k), 16'h0000);
      foreach (EDGE_FREQS[i]) begin
        queue_freq(25'(EDGE_FREQS[i]));
      end
      drain();
    end

    // random settings, each followed by a batch of random frequencies
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_settings(random_setting(), 16'($urandom));
      no_gaps <= (p == CALM_PHASE);
      n = (p == CALM_PHASE) ? CALM_ITEMS : PHASE_ITEMS;
      repeat (n) queue_freq(random_freq());
      drain();
    end

    if (expected_words.size() != 0) begin
      mismatches++;
      $display("%0d predictions never matched by a result", expected_words.size());
    end
    if (mismatches == 0) begin
      $display("tb_tuning_word_generator_unit: clean");
    end else begin
      $display("tb_tuning_word_generator_unit: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
